[hw/rtl/tfn_pkg.sv]
// Shared widths and payload types for the triangle face normal pipeline.
// Used by every module of the block; depends on nothing.
package tfn_pkg;

    localparam int CoordW   = 16;
    localparam int EdgeW    = CoordW + 1;
    localparam int ProdW    = 2 * EdgeW;
    localparam int CrossW   = ProdW + 1;
    localparam int MagW     = ProdW;
    localparam int TopW     = $clog2(MagW);
    localparam int NormTop  = 29;
    localparam int RW       = NormTop + 1;
    localparam int SqW      = 2 * RW;
    localparam int SumW     = SqW + 2;
    localparam int LenW     = SumW / 2;
    localparam int RemW     = LenW + 2;
    localparam int NormFrac = 14;
    localparam int QW       = NormFrac + 1;
    localparam int NumW     = RW + NormFrac + 1;
    localparam int OutW     = 16;

    typedef logic [RW-1:0] t_mag;

    typedef struct packed {
        t_mag [2:0] r;
        logic [2:0] neg;
        logic       degen;
    } t_norm;

endpackage

[hw/rtl/tfn_front.sv]
// Front end: edges, cross product, normalisation shift and squared length.
// Seven register stages; depends on tfn_pkg.
module tfn_front
    import tfn_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [CoordW-1:0] i_v1 [3],
    input  logic signed [CoordW-1:0] i_v2 [3],
    input  logic signed [CoordW-1:0] i_v3 [3],
    output logic                     o_valid,
    output t_norm                    o_norm,
    output logic [SumW-1:0]          o_sum
);

    logic [7:1] r_v;
    logic signed [EdgeW-1:0]  r_a [3];
    logic signed [EdgeW-1:0]  r_b [3];
    logic signed [ProdW-1:0]  r_p [6];
    logic [MagW-1:0]          r_mag3 [3];
    logic [2:0]               r_neg3;
    logic [MagW-1:0]          r_mag4 [3];
    logic [2:0]               r_neg4;
    logic                     r_dg4;
    logic [TopW-1:0]          r_top;
    t_norm                    r_n5, r_n6, r_n7;
    logic [SqW-1:0]           r_sq [3];
    logic [SumW-1:0]          r_sum;

    logic signed [CrossW-1:0] c [3];
    logic [MagW-1:0]          or_m;
    logic [TopW-1:0]          top;
    logic [MagW-1:0]          sh [3];

    always_comb begin
        c[0] = CrossW'(r_p[0]) - CrossW'(r_p[1]);
        c[1] = CrossW'(r_p[2]) - CrossW'(r_p[3]);
        c[2] = CrossW'(r_p[4]) - CrossW'(r_p[5]);
    end

    always_comb begin
        or_m = r_mag3[0] | r_mag3[1] | r_mag3[2];
        top  = '0;
        for (int j = 0; j < MagW; j++) begin
            if (or_m[j]) begin
                top = TopW'(j);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_top > TopW'(NormTop)) begin
                sh[i] = r_mag4[i] >> (r_top - TopW'(NormTop));
            end else begin
                sh[i] = r_mag4[i] << (TopW'(NormTop) - r_top);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= EdgeW'(i_v1[i]) - EdgeW'(i_v2[i]);
                r_b[i] <= EdgeW'(i_v1[i]) - EdgeW'(i_v3[i]);
            end
            r_p[0] <= r_a[1] * r_b[2];
            r_p[1] <= r_b[1] * r_a[2];
            r_p[2] <= r_b[0] * r_a[2];
            r_p[3] <= r_a[0] * r_b[2];
            r_p[4] <= r_a[0] * r_b[1];
            r_p[5] <= r_b[0] * r_a[1];
            for (int i = 0; i < 3; i++) begin
                r_neg3[i] <= c[i][CrossW-1];
                r_mag3[i] <= c[i][CrossW-1] ? MagW'(-c[i]) : MagW'(c[i]);
            end
            r_mag4 <= r_mag3;
            r_neg4 <= r_neg3;
            r_dg4  <= (or_m == '0);
            r_top  <= top;
            for (int i = 0; i < 3; i++) begin
                r_n5.r[i] <= sh[i][RW-1:0];
            end
            r_n5.neg   <= r_neg4;
            r_n5.degen <= r_dg4;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_n5.r[i] * r_n5.r[i];
            end
            r_n6  <= r_n5;
            r_sum <= SumW'(r_sq[0]) + SumW'(r_sq[1]) + SumW'(r_sq[2]);
            r_n7  <= r_n6;
        end
    end

    assign o_valid = r_v[7];
    assign o_norm  = r_n7;
    assign o_sum   = r_sum;

endmodule

[hw/rtl/tfn_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Carries the normalised components alongside; depends on tfn_pkg.
module tfn_sqrt
    import tfn_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_norm           i_norm,
    input  logic [SumW-1:0] i_sum,
    output logic            o_valid,
    output t_norm           o_norm,
    output logic [LenW-1:0] o_len
);

    logic [LenW-1:0] r_v;
    logic [RemW-1:0] r_rem  [LenW];
    logic [LenW-1:0] r_root [LenW];
    logic [SumW-1:0] r_s    [LenW];
    t_norm           r_n    [LenW];

    for (genvar k = 0; k < LenW; k++) begin : g_stage
        logic [RemW-1:0] rem_in;
        logic [LenW-1:0] root_in;
        logic [SumW-1:0] s_in;
        t_norm           n_in;
        logic            v_in;
        logic [RemW+1:0] cur;
        logic [RemW+1:0] trial;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign s_in    = i_sum;
            assign n_in    = i_norm;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign s_in    = r_s[k-1];
            assign n_in    = r_n[k-1];
            assign v_in    = r_v[k-1];
        end

        assign cur   = {rem_in, s_in[SumW-1-2*k -: 2]};
        assign trial = {2'b00, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k] <= s_in;
                r_n[k] <= n_in;
                if (cur >= trial) begin
                    r_rem[k]  <= RemW'(cur - trial);
                    r_root[k] <= {root_in[LenW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= RemW'(cur);
                    r_root[k] <= {root_in[LenW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[LenW-1];
    assign o_norm  = r_n[LenW-1];
    assign o_len   = r_root[LenW-1];

endmodule

[hw/rtl/tfn_div.sv]
// Pipelined rounding divider: each component times 2^14 over the length.
// One numerator stage then one quotient bit per stage; depends on tfn_pkg.
module tfn_div
    import tfn_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_norm           i_norm,
    input  logic [LenW-1:0] i_len,
    output logic            o_valid,
    output logic [2:0]      o_neg,
    output logic            o_degen,
    output logic [QW-1:0]   o_q [3]
);

    logic            r_v0;
    logic [NumW-1:0] r_num0 [3];
    logic [LenW-1:0] r_len0;
    logic [2:0]      r_neg0;
    logic            r_dg0;

    logic [QW-1:0]   r_v;
    logic [LenW-1:0] r_rem [QW][3];
    logic [QW-1:0]   r_q   [QW][3];
    logic [NumW-1:0] r_num [QW][3];
    logic [LenW-1:0] r_len [QW];
    logic [2:0]      r_neg [QW];
    logic            r_dg  [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_num0[i] <= {1'b0, i_norm.r[i], {NormFrac{1'b0}}}
                           + NumW'(i_len >> 1);
            end
            r_len0 <= i_len;
            r_neg0 <= i_norm.neg;
            r_dg0  <= i_norm.degen;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [LenW-1:0] rem_in [3];
        logic [QW-1:0]   q_in   [3];
        logic [NumW-1:0] num_in [3];
        logic [LenW-1:0] len_in;
        logic [2:0]      neg_in;
        logic            dg_in;
        logic            v_in;
        logic [LenW:0]   cur [3];

        if (k == 0) begin : g_first
            for (genvar i = 0; i < 3; i++) begin : g_c
                assign rem_in[i] = LenW'(r_num0[i][NumW-1:QW]);
                assign q_in[i]   = '0;
                assign num_in[i] = r_num0[i];
            end
            assign len_in = r_len0;
            assign neg_in = r_neg0;
            assign dg_in  = r_dg0;
            assign v_in   = r_v0;
        end else begin : g_next
            for (genvar i = 0; i < 3; i++) begin : g_c
                assign rem_in[i] = r_rem[k-1][i];
                assign q_in[i]   = r_q[k-1][i];
                assign num_in[i] = r_num[k-1][i];
            end
            assign len_in = r_len[k-1];
            assign neg_in = r_neg[k-1];
            assign dg_in  = r_dg[k-1];
            assign v_in   = r_v[k-1];
        end

        for (genvar i = 0; i < 3; i++) begin : g_cur
            assign cur[i] = {rem_in[i], num_in[i][QW-1-k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[k] <= len_in;
                r_neg[k] <= neg_in;
                r_dg[k]  <= dg_in;
                for (int i = 0; i < 3; i++) begin
                    r_num[k][i] <= num_in[i];
                    if (cur[i] >= {1'b0, len_in}) begin
                        r_rem[k][i] <= LenW'(cur[i] - {1'b0, len_in});
                        r_q[k][i]   <= {q_in[i][QW-2:0], 1'b1};
                    end else begin
                        r_rem[k][i] <= LenW'(cur[i]);
                        r_q[k][i]   <= {q_in[i][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_neg   = r_neg[QW-1];
    assign o_degen = r_dg[QW-1];
    assign o_q     = r_q[QW-1];

endmodule

[hw/rtl/triangle_face_normal.sv]
// Top level of the triangle face normal pipeline and its output register.
// Depends on tfn_pkg, tfn_front, tfn_sqrt and tfn_div.
//
// One triangle (three vertices, signed Q8.8) enters on the input channel
// when i_valid is high and o_stall is low. The unit face normal (signed
// Q1.14) and the degenerate flag leave on the output channel when o_valid
// is high and i_stall is low. A triangle whose cross product is zero gives
// a zero normal with o_degenerate set.
// From acceptance to o_valid an item passes seven front stages, 31
// square root stages (one root bit each), 16 divider stages (one
// quotient bit each after the numerator) and the output register.
// Throughput is one item per cycle while o_stall is low.
// While the receiver stalls a waiting item, every stage holds and o_stall
// is raised; nothing is lost or repeated. Bubbles travel with the items.
// Reset clears all valid bits, so no item is shown after reset.
module triangle_face_normal
    import tfn_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [CoordW-1:0] i_v1_x,
    input  logic signed [CoordW-1:0] i_v1_y,
    input  logic signed [CoordW-1:0] i_v1_z,
    input  logic signed [CoordW-1:0] i_v2_x,
    input  logic signed [CoordW-1:0] i_v2_y,
    input  logic signed [CoordW-1:0] i_v2_z,
    input  logic signed [CoordW-1:0] i_v3_x,
    input  logic signed [CoordW-1:0] i_v3_y,
    input  logic signed [CoordW-1:0] i_v3_z,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [OutW-1:0]   o_normal_x,
    output logic signed [OutW-1:0]   o_normal_y,
    output logic signed [OutW-1:0]   o_normal_z,
    output logic                     o_degenerate
);

    logic                     en;
    logic signed [CoordW-1:0] v1 [3];
    logic signed [CoordW-1:0] v2 [3];
    logic signed [CoordW-1:0] v3 [3];
    logic                     f_valid;
    t_norm                    f_norm;
    logic [SumW-1:0]          f_sum;
    logic                     s_valid;
    t_norm                    s_norm;
    logic [LenW-1:0]          s_len;
    logic                     d_valid;
    logic [2:0]               d_neg;
    logic                     d_degen;
    logic [QW-1:0]            d_q [3];
    logic [OutW-1:0]          n_out [3];
    logic                     r_ovld;
    logic [OutW-1:0]          r_out [3];
    logic                     r_dg;

    assign en      = !(r_ovld && i_stall);
    assign o_stall = r_ovld && i_stall;

    assign v1 = '{i_v1_x, i_v1_y, i_v1_z};
    assign v2 = '{i_v2_x, i_v2_y, i_v2_z};
    assign v3 = '{i_v3_x, i_v3_y, i_v3_z};

    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_v1    (v1),
        .i_v2    (v2),
        .i_v3    (v3),
        .o_valid (f_valid),
        .o_norm  (f_norm),
        .o_sum   (f_sum)
    );

    tfn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_norm  (f_norm),
        .i_sum   (f_sum),
        .o_valid (s_valid),
        .o_norm  (s_norm),
        .o_len   (s_len)
    );

    tfn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_norm  (s_norm),
        .i_len   (s_len),
        .o_valid (d_valid),
        .o_neg   (d_neg),
        .o_degen (d_degen),
        .o_q     (d_q)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [OutW-1:0] mag;
            mag = (d_q[i] > QW'(1 << NormFrac)) ? OutW'(1 << NormFrac) : OutW'(d_q[i]);
            if (d_degen) begin
                n_out[i] = '0;
            end else if (d_neg[i]) begin
                n_out[i] = -mag;
            end else begin
                n_out[i] = mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
            r_dg  <= d_degen;
        end
    end

    assign o_valid      = r_ovld;
    assign o_normal_x   = r_out[0];
    assign o_normal_y   = r_out[1];
    assign o_normal_z   = r_out[2];
    assign o_degenerate = r_dg;

endmodule
